>>> hdl/qmm_pkg.sv
// ----------------------------------------------------------------------------
// qmm_pkg: shared types and constants of the quadrotor motor mixer
// Beat payloads, configuration register indexes, reset values and the
// fixed widths of the fixed-point datapath.
// ----------------------------------------------------------------------------
package qmm_pkg;

	// Mix modes. The two remaining codes give idle on every motor.
	localparam logic [1:0] MODE_LEGACY = 2'd0;
	localparam logic [1:0] MODE_FORCE  = 2'd1;

	// Configuration register indexes.
	localparam logic [2:0] CFG_ARM_LENGTH      = 3'd0;
	localparam logic [2:0] CFG_TORQUE_RATIO    = 3'd1;
	localparam logic [2:0] CFG_CURVE_QUADRATIC = 3'd2;
	localparam logic [2:0] CFG_CURVE_LINEAR    = 3'd3;
	localparam logic [2:0] CFG_IDLE_LEVEL      = 3'd4;

	localparam logic [23:0] ARM_LENGTH_RST      = 24'd771752;
	localparam logic [23:0] TORQUE_RATIO_RST    = 24'd100069;
	localparam logic [23:0] CURVE_QUADRATIC_RST = 24'd1534992;
	localparam logic [23:0] CURVE_LINEAR_RST    = 24'd1135375;
	localparam logic [15:0] IDLE_LEVEL_RST      = 16'd0;

	// 0.707106781 in unsigned Q0.24.
	localparam logic [23:0] DIAG_Q24 = 24'd11863283;

	localparam int COEF_W     = 24;
	localparam int ARM_DEN_W  = 48;  // diagonal constant times arm length
	localparam int TQ_NUM_W   = 80;  // 32-bit magnitude shifted up by 48
	localparam int PART_Q_W   = 56;  // largest torque quotient magnitude
	localparam int PART_W     = 57;  // signed torque part
	localparam int ROTOR_W    = 59;  // signed rotor force before clamping
	localparam int FCLAMP_W   = 39;  // clamped rotor force
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int WNUM_W     = 48;  // 65535 * (root - linear coefficient)
	localparam int WDEN_W     = 25;  // twice the quadratic coefficient
	localparam int LEG_W      = 18;  // legacy mix word
	localparam int M_W        = 49;  // signed uncapped motor word
	localparam int WORD_MAX   = 65535;

	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        thrust_cmd;
		logic signed [15:0] roll_cmd;
		logic signed [15:0] pitch_cmd;
		logic signed [15:0] yaw_cmd;
		logic signed [31:0] force_total;
		logic signed [31:0] torque_roll;
		logic signed [31:0] torque_pitch;
		logic signed [31:0] torque_yaw;
	} cmd_t;

	typedef struct packed {
		logic [15:0] motor_one;
		logic [15:0] motor_two;
		logic [15:0] motor_three;
		logic [15:0] motor_four;
	} motor_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [23:0] value;
	} cfg_wr_t;

	// Effective coefficients as the datapath uses them.
	typedef struct packed {
		logic [ARM_DEN_W-1:0] arm_den;
		logic [COEF_W-1:0]    kr;
		logic [COEF_W-1:0]    a;
		logic [COEF_W-1:0]    b;
		logic [WDEN_W-1:0]    a2;
		logic [47:0]          bb;
		logic [15:0]          idle;
	} cfg_t;

endpackage

>>> hdl/qmm_if.sv
// ----------------------------------------------------------------------------
// qmm_if: handshake channels of the quadrotor motor mixer
// Command input, motor output and configuration write channels.
// ----------------------------------------------------------------------------
interface qmm_cmd_if;
	logic          valid;
	logic          ready;
	qmm_pkg::cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qmm_motor_if;
	logic            valid;
	logic            ready;
	qmm_pkg::motor_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qmm_cfg_if;
	logic             valid;
	logic             ready;
	qmm_pkg::cfg_wr_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/qmm_cfg.sv
// ----------------------------------------------------------------------------
// qmm_cfg: configuration registers
// Holds the five registers and derives the effective coefficients.
// ----------------------------------------------------------------------------
module qmm_cfg (
	input  logic          clk,
	input  logic          arst_n,
	qmm_cfg_if.sink       cfg,
	output qmm_pkg::cfg_t eff
);
	import qmm_pkg::*;

	logic [23:0] arm_q, ratio_q, quad_q, lin_q;
	logic [15:0] idle_q;
	logic [47:0] den_q, bb_q;
	logic [23:0] len_eff, kr_eff, a_eff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_q   <= ARM_LENGTH_RST;
			ratio_q <= TORQUE_RATIO_RST;
			quad_q  <= CURVE_QUADRATIC_RST;
			lin_q   <= CURVE_LINEAR_RST;
			idle_q  <= IDLE_LEVEL_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				CFG_ARM_LENGTH:      arm_q   <= cfg.data.value;
				CFG_TORQUE_RATIO:    ratio_q <= cfg.data.value;
				CFG_CURVE_QUADRATIC: quad_q  <= cfg.data.value;
				CFG_CURVE_LINEAR:    lin_q   <= cfg.data.value;
				CFG_IDLE_LEVEL:      idle_q  <= cfg.data.value[15:0];
				default: ;
			endcase
		end
	end

	// A zero arm length, torque ratio or quadratic coefficient is treated as one.
	assign len_eff = (arm_q == '0) ? 24'd1 : arm_q;
	assign kr_eff  = (ratio_q == '0) ? 24'd1 : ratio_q;
	assign a_eff   = (quad_q == '0) ? 24'd1 : quad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= 48'(DIAG_Q24) * 48'(ARM_LENGTH_RST);
			bb_q  <= 48'(CURVE_LINEAR_RST) * 48'(CURVE_LINEAR_RST);
		end else begin
			den_q <= 48'(DIAG_Q24) * 48'(len_eff);
			bb_q  <= 48'(lin_q) * 48'(lin_q);
		end
	end

	assign eff.arm_den = den_q;
	assign eff.kr      = kr_eff;
	assign eff.a       = a_eff;
	assign eff.b       = lin_q;
	assign eff.a2      = {a_eff, 1'b0};
	assign eff.bb      = bb_q;
	assign eff.idle    = idle_q;

endmodule

>>> hdl/qmm_div_pipe.sv
// ----------------------------------------------------------------------------
// qmm_div_pipe: pipelined restoring divider
// One quotient bit per stage over several lanes that share a sideband tag.
// ----------------------------------------------------------------------------
module qmm_div_pipe #(
	parameter int LANES = 1,
	parameter int NUM_W = 8,
	parameter int DEN_W = 8,
	parameter int TAG_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [LANES-1:0][NUM_W-1:0] num,
	input  logic [LANES-1:0][DEN_W-1:0] den,
	input  logic [TAG_W-1:0]            tag_in,
	output logic                        out_valid,
	output logic [LANES-1:0][NUM_W-1:0] quo,
	output logic [TAG_W-1:0]            tag_out
);
	logic [LANES-1:0][DEN_W-1:0] rem_s [1:NUM_W];
	logic [LANES-1:0][NUM_W-1:0] nq_s  [1:NUM_W];
	logic [TAG_W-1:0]            tag_s [1:NUM_W];
	logic [NUM_W-1:0]            vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NUM_W-2:0], in_valid};
		end
	end

	for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
		logic [LANES-1:0][DEN_W-1:0] prev_rem, rem_d;
		logic [LANES-1:0][NUM_W-1:0] prev_nq, nq_d;
		logic [TAG_W-1:0]            prev_tag;

		if (k == 1) begin : g_first
			assign prev_rem = '0;
			assign prev_nq  = num;
			assign prev_tag = tag_in;
		end else begin : g_next
			assign prev_rem = rem_s[k-1];
			assign prev_nq  = nq_s[k-1];
			assign prev_tag = tag_s[k-1];
		end

		// Shift in the next dividend bit and subtract when the divisor fits.
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				logic [DEN_W:0] trial;
				logic           ge;
				trial = {prev_rem[l], prev_nq[l][NUM_W-1]};
				ge    = (trial >= {1'b0, den[l]});
				rem_d[l] = ge ? DEN_W'(trial - {1'b0, den[l]}) : trial[DEN_W-1:0];
				nq_d[l]  = {prev_nq[l][NUM_W-2:0], ge};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_d;
				nq_s[k]  <= nq_d;
				tag_s[k] <= prev_tag;
			end
		end
	end

	assign out_valid = vld_q[NUM_W-1];
	assign quo       = nq_s[NUM_W];
	assign tag_out   = tag_s[NUM_W];

endmodule

>>> hdl/qmm_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// qmm_sqrt_pipe: pipelined integer square root
// Floor square root of a 64-bit radicand, one result bit per stage.
// ----------------------------------------------------------------------------
module qmm_sqrt_pipe #(
	parameter int LANES = 1,
	parameter int TAG_W = 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic [LANES-1:0][qmm_pkg::RAD_W-1:0]  rad,
	input  logic [TAG_W-1:0]                      tag_in,
	output logic                                  out_valid,
	output logic [LANES-1:0][qmm_pkg::ROOT_W-1:0] root,
	output logic [TAG_W-1:0]                      tag_out
);
	import qmm_pkg::*;

	localparam int STAGES = ROOT_W;

	logic [LANES-1:0][RAD_W-1:0] rem_s [1:STAGES];
	logic [LANES-1:0][RAD_W-1:0] res_s [1:STAGES];
	logic [TAG_W-1:0]            tag_s [1:STAGES];
	logic [STAGES-1:0]           vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-2:0], in_valid};
		end
	end

	for (genvar k = 1; k <= STAGES; k++) begin : g_stage
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 * k);
		logic [LANES-1:0][RAD_W-1:0] prev_rem, prev_res, rem_d, res_d;
		logic [TAG_W-1:0]            prev_tag;

		if (k == 1) begin : g_first
			assign prev_rem = rad;
			assign prev_res = '0;
			assign prev_tag = tag_in;
		end else begin : g_next
			assign prev_rem = rem_s[k-1];
			assign prev_res = res_s[k-1];
			assign prev_tag = tag_s[k-1];
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				logic [RAD_W-1:0] trial;
				trial = prev_res[l] + BIT;
				if (prev_rem[l] >= trial) begin
					rem_d[l] = prev_rem[l] - trial;
					res_d[l] = (prev_res[l] >> 1) + BIT;
				end else begin
					rem_d[l] = prev_rem[l];
					res_d[l] = prev_res[l] >> 1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_d;
				res_s[k] <= res_d;
				tag_s[k] <= prev_tag;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			root[l] = res_s[STAGES][l][ROOT_W-1:0];
		end
	end

	assign out_valid = vld_q[STAGES-1];
	assign tag_out   = tag_s[STAGES];

endmodule

>>> hdl/quadrotor_motor_mixer.sv
// ----------------------------------------------------------------------------
// quadrotor_motor_mixer: X-frame quadrotor motor mixer
// One command beat in, four capped motor drive words out, fully pipelined.
// ----------------------------------------------------------------------------
// The mixer accepts one command beat every clock cycle while the motor channel
// does not stall, and returns one motor beat per command, in order. The pipeline
// is built around the bit-serial pipelines: an 80-stage divider for the
// torque terms, a 32-stage square root for the thrust curve and a 48-stage
// divider for the final scaling, plus nine single stages around them. A stall
// on the motor channel freezes the whole pipeline, so nothing is lost or
// repeated; command ready drops only while a finished motor beat waits.
// Mode 0 mixes the legacy 16-bit commands, mode 1 converts force and torques
// through the thrust curve, and the other modes give idle on every motor.
// Configuration writes are accepted at any time and must be made only while
// no command is in flight.
module quadrotor_motor_mixer (
	input  logic        clk,
	input  logic        arst_n,
	qmm_cmd_if.sink     cmd,
	qmm_motor_if.source motors,
	qmm_cfg_if.sink     cfg
);
	import qmm_pkg::*;

	localparam int TAG1_W = 2 + 4 * LEG_W + 32 + 3;
	localparam int TAG2_W = 2 + 4 * LEG_W;
	localparam logic signed [M_W-1:0] WORD_CAP = M_W'(WORD_MAX);
	localparam logic [FCLAMP_W-1:0] FORCE_MAX = '1;

	cfg_t eff;
	logic en;

	qmm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.eff    (eff)
	);

	// The whole pipeline moves together; it holds only when the output
	// register is full and the consumer does not take it.
	logic v_s9;
	assign en        = !v_s9 || motors.ready;
	assign cmd.ready = en;

	// ------------------------------------------------------------------
	// Stage 1: legacy mix and torque magnitudes.
	// ------------------------------------------------------------------
	logic signed [16:0] roll_x, pitch_x, roll_h, pitch_h;
	logic signed [LEG_W-1:0] t_l, r_l, p_l, y_l;
	logic [3:0][LEG_W-1:0] leg_d;
	logic [2:0][31:0] mag_d;
	logic [2:0] sgn_d;

	always_comb begin
		// The arithmetic shift rounds down, so negative values get one added first and halving truncates toward zero.
		roll_x  = {cmd.data.roll_cmd[15], cmd.data.roll_cmd};
		pitch_x = {cmd.data.pitch_cmd[15], cmd.data.pitch_cmd};
		roll_h  = (roll_x + $signed({16'b0, cmd.data.roll_cmd[15]})) >>> 1;
		pitch_h = (pitch_x + $signed({16'b0, cmd.data.pitch_cmd[15]})) >>> 1;
		t_l = {2'b0, cmd.data.thrust_cmd};
		r_l = {roll_h[16], roll_h};
		p_l = {pitch_h[16], pitch_h};
		y_l = {{2{cmd.data.yaw_cmd[15]}}, cmd.data.yaw_cmd};
		leg_d[0] = t_l - r_l + p_l + y_l;
		leg_d[1] = t_l - r_l - p_l - y_l;
		leg_d[2] = t_l + r_l - p_l + y_l;
		leg_d[3] = t_l + r_l + p_l - y_l;
		sgn_d = {cmd.data.torque_yaw[31], cmd.data.torque_pitch[31],
			cmd.data.torque_roll[31]};
		mag_d[0] = sgn_d[0] ? (~cmd.data.torque_roll + 32'd1) : cmd.data.torque_roll;
		mag_d[1] = sgn_d[1] ? (~cmd.data.torque_pitch + 32'd1) : cmd.data.torque_pitch;
		mag_d[2] = sgn_d[2] ? (~cmd.data.torque_yaw + 32'd1) : cmd.data.torque_yaw;
	end

	logic               v_s1;
	logic [1:0]         mode_s1;
	logic [3:0][LEG_W-1:0] leg_s1;
	logic signed [31:0] t_s1;
	logic [2:0]         sgn_s1;
	logic [2:0][31:0]   mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= cmd.data.mode;
			leg_s1  <= leg_d;
			t_s1    <= cmd.data.force_total;
			sgn_s1  <= sgn_d;
			mag_s1  <= mag_d;
		end
	end

	// ------------------------------------------------------------------
	// Torque division: roll and pitch over the diagonal arm, yaw over the
	// torque ratio. Yaw is shifted by 24 only, so it sits lower in the word.
	// ------------------------------------------------------------------
	logic [2:0][TQ_NUM_W-1:0] tq_num, tq_quo;
	logic [2:0][ARM_DEN_W-1:0] tq_den;
	logic [TAG1_W-1:0] tag1_out;
	logic v_d1;

	assign tq_num[0] = {mag_s1[0], 48'b0};
	assign tq_num[1] = {mag_s1[1], 48'b0};
	assign tq_num[2] = {24'b0, mag_s1[2], 24'b0};
	assign tq_den[0] = eff.arm_den;
	assign tq_den[1] = eff.arm_den;
	assign tq_den[2] = {24'b0, eff.kr};

	qmm_div_pipe #(
		.LANES (3),
		.NUM_W (TQ_NUM_W),
		.DEN_W (ARM_DEN_W),
		.TAG_W (TAG1_W)
	) u_torque_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.num       (tq_num),
		.den       (tq_den),
		.tag_in    ({mode_s1, leg_s1, t_s1, sgn_s1}),
		.out_valid (v_d1),
		.quo       (tq_quo),
		.tag_out   (tag1_out)
	);

	logic [1:0]         mode_d1;
	logic [3:0][LEG_W-1:0] leg_d1;
	logic signed [31:0] t_d1;
	logic [2:0]         sgn_d1;

	assign {mode_d1, leg_d1, t_d1, sgn_d1} = tag1_out;

	// ------------------------------------------------------------------
	// Stage 2: restore the torque signs.
	// ------------------------------------------------------------------
	logic                     v_s2;
	logic [1:0]               mode_s2;
	logic [3:0][LEG_W-1:0]    leg_s2;
	logic signed [31:0]       t_s2;
	logic signed [PART_W-1:0] part_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_d1;
			leg_s2  <= leg_d1;
			t_s2    <= t_d1;
			for (int l = 0; l < 3; l++) begin
				part_s2[l] <= sgn_d1[l] ? (~{1'b0, tq_quo[l][PART_Q_W-1:0]} + PART_W'(1))
					: {1'b0, tq_quo[l][PART_Q_W-1:0]};
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: per-rotor forces in the X pattern.
	// ------------------------------------------------------------------
	logic signed [ROTOR_W-1:0] tf, rf, pf, yf;
	logic                      v_s3;
	logic [1:0]                mode_s3;
	logic [3:0][LEG_W-1:0]     leg_s3;
	logic signed [ROTOR_W-1:0] f_s3 [4];

	assign tf = ROTOR_W'(t_s2);
	assign rf = ROTOR_W'(part_s2[0]);
	assign pf = ROTOR_W'(part_s2[1]);
	assign yf = ROTOR_W'(part_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3 <= mode_s2;
			leg_s3  <= leg_s2;
			f_s3[0] <= tf - rf - pf - yf;
			f_s3[1] <= tf - rf + pf + yf;
			f_s3[2] <= tf + rf + pf - yf;
			f_s3[3] <= tf + rf - pf + yf;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: clamp each force to its legal range and form the partial
	// products of the quadratic coefficient times the force.
	// ------------------------------------------------------------------
	logic [FCLAMP_W-1:0]   fc [4];
	logic                  v_s4;
	logic [1:0]            mode_s4;
	logic [3:0][LEG_W-1:0] leg_s4;
	logic [47:0]           plo_s4 [4];
	logic [FCLAMP_W-1:0]   phi_s4 [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (f_s3[i][ROTOR_W-1]) begin
				fc[i] = '0;
			end else if (|f_s3[i][ROTOR_W-2:FCLAMP_W]) begin
				fc[i] = FORCE_MAX;
			end else begin
				fc[i] = f_s3[i][FCLAMP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s4 <= mode_s3;
			leg_s4  <= leg_s3;
			for (int i = 0; i < 4; i++) begin
				plo_s4[i] <= 48'(eff.a) * 48'(fc[i][23:0]);
				phi_s4[i] <= FCLAMP_W'(eff.a) * FCLAMP_W'(fc[i][FCLAMP_W-1:24]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: radicand B*B + A*F.
	// ------------------------------------------------------------------
	logic                        v_s5;
	logic [1:0]                  mode_s5;
	logic [3:0][LEG_W-1:0]       leg_s5;
	logic [3:0][RAD_W-1:0]       rad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s5 <= mode_s4;
			leg_s5  <= leg_s4;
			for (int i = 0; i < 4; i++) begin
				rad_s5[i] <= RAD_W'(eff.bb) + {1'b0, phi_s4[i], 24'b0}
					+ RAD_W'(plo_s4[i]);
			end
		end
	end

	logic [3:0][ROOT_W-1:0] root;
	logic [TAG2_W-1:0]      tag_sq;
	logic                   v_sq;

	qmm_sqrt_pipe #(
		.LANES (4),
		.TAG_W (TAG2_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.rad       (rad_s5),
		.tag_in    ({mode_s5, leg_s5}),
		.out_valid (v_sq),
		.root      (root),
		.tag_out   (tag_sq)
	);

	// ------------------------------------------------------------------
	// Stage 6: 65535 * (S - B) as a shift and subtract. S never falls
	// below B, since the radicand is at least B*B.
	// ------------------------------------------------------------------
	logic [ROOT_W-1:0]       dif [4];
	logic                    v_s6;
	logic [TAG2_W-1:0]       tag_s6;
	logic [3:0][WNUM_W-1:0]  wnum_s6;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			dif[i] = root[i] - ROOT_W'(eff.b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s6 <= tag_sq;
			for (int i = 0; i < 4; i++) begin
				wnum_s6[i] <= {dif[i], 16'b0} - {16'b0, dif[i]};
			end
		end
	end

	logic [3:0][WNUM_W-1:0] wquo;
	logic [TAG2_W-1:0]      tag_d2;
	logic                   v_d2;

	qmm_div_pipe #(
		.LANES (4),
		.NUM_W (WNUM_W),
		.DEN_W (WDEN_W),
		.TAG_W (TAG2_W)
	) u_word_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (wnum_s6),
		.den       ({4{eff.a2}}),
		.tag_in    (tag_s6),
		.out_valid (v_d2),
		.quo       (wquo),
		.tag_out   (tag_d2)
	);

	logic [1:0]            mode_d2;
	logic [3:0][LEG_W-1:0] leg_d2;

	assign {mode_d2, leg_d2} = tag_d2;

	// ------------------------------------------------------------------
	// Stage 7: pick the uncapped words for the mode.
	// ------------------------------------------------------------------
	logic                  v_s7;
	logic signed [M_W-1:0] m_s7 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				case (mode_d2)
					MODE_LEGACY: m_s7[i] <= M_W'($signed(leg_d2[i]));
					MODE_FORCE:  m_s7[i] <= {1'b0, wquo[i]};
					default:     m_s7[i] <= '0;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: the excess of the largest word over full scale.
	// ------------------------------------------------------------------
	logic signed [M_W-1:0] highest, red_d;
	logic                  v_s8;
	logic signed [M_W-1:0] m_s8 [4];
	logic signed [M_W-1:0] red_s8;

	always_comb begin
		highest = '0;
		for (int i = 0; i < 4; i++) begin
			if (m_s7[i] > highest) begin
				highest = m_s7[i];
			end
		end
		red_d = (highest > WORD_CAP) ? (highest - WORD_CAP) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s8   <= m_s7;
			red_s8 <= red_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: shift down by the excess and raise to the idle floor. This
	// is the output register.
	// ------------------------------------------------------------------
	logic signed [M_W-1:0] idle_m;
	logic signed [M_W-1:0] lowered [4];
	logic [15:0]           word [4];
	motor_t                motor_s9;

	assign idle_m = M_W'(eff.idle);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lowered[i] = m_s8[i] - red_s8;
			word[i]    = (lowered[i] < idle_m) ? eff.idle : lowered[i][15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			motor_s9.motor_one   <= word[0];
			motor_s9.motor_two   <= word[1];
			motor_s9.motor_three <= word[2];
			motor_s9.motor_four  <= word[3];
		end
	end

	assign motors.valid = v_s9;
	assign motors.data  = motor_s9;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// An accepted command always occupies the first stage next cycle.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> v_s1)
		else $error("accepted command did not enter the pipeline");

	// When a reduction is applied, some motor lands exactly on full scale.
	a_cap_hits_max: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && (red_s8 != '0) |->
			(m_s8[0] - red_s8 == WORD_CAP) || (m_s8[1] - red_s8 == WORD_CAP) ||
			(m_s8[2] - red_s8 == WORD_CAP) || (m_s8[3] - red_s8 == WORD_CAP))
		else $error("capping reduction does not match the largest motor");

	// No motor word is ever delivered below the idle floor.
	a_idle_floor: assert property (@(posedge clk) disable iff (!arst_n)
		motors.valid |-> (motors.data.motor_one >= eff.idle) &&
			(motors.data.motor_two >= eff.idle) &&
			(motors.data.motor_three >= eff.idle) &&
			(motors.data.motor_four >= eff.idle))
		else $error("motor word below idle level");

endmodule
